// ===== rtl/bbag_pkg.sv =====
// ----------------------------------------------------------------------------
// bbag_pkg
// Types and constants for the basic block address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bbag_pkg;

  localparam int ADDR_W        = 64;
  localparam int LEN_W         = 8;
  localparam int BLOCK_INDEX_W = 10;
  localparam int STEP_W        = 12;
  localparam int LIMIT_W       = 16;
  localparam int COUNT_W       = 16;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_UNIQUE_LIMIT = CFG_IDX_W'(1);

  localparam logic [STEP_W-1:0]  ADDRESS_STEP_RST = STEP_W'(4);
  localparam logic [LIMIT_W-1:0] UNIQUE_LIMIT_RST = LIMIT_W'(1024);
  localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

  typedef struct packed {
    logic [ADDR_W-1:0] fresh_addr;
    logic [LEN_W-1:0]  fresh_len;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]        inst_addr;
    logic                     block_end;
    logic [BLOCK_INDEX_W-1:0] block_index;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/basic_block_address_generator_unit.sv =====
// ----------------------------------------------------------------------------
// basic_block_address_generator_unit
// Timing: done follows start in the next cycle; when a block end follows a
// stored link, the block table read (link_wait) comes between. Throughput:
// one word per cycle, except that a linked block entry holds busy meanwhile.
// Reset: synchronous; control state clears, block table is not cleared.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module basic_block_address_generator_unit
  import bbag_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire req_t                  req,
  output      logic                  done,
  output      result_t               result,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IW:0] DEPTH_CNT = (IW+1)'(TABLE_DEPTH);
  localparam logic [IW:0] LINK_ONE  = (IW+1)'(1);

  // block table
  logic [ADDR_W-1:0] start_mem [0:TABLE_DEPTH-1];
  logic [LEN_W-1:0]  len_mem   [0:TABLE_DEPTH-1];
  logic [IW:0]       next_mem  [0:TABLE_DEPTH-1];
  logic [ADDR_W-1:0] rd_start;
  logic [LEN_W-1:0]  rd_len;
  logic [IW:0]       rd_next;

  // config
  logic [STEP_W-1:0]  address_step;
  logic [LIMIT_W-1:0] unique_limit;

  // walk state
  logic              started;
  logic [ADDR_W-1:0] cur_addr;
  logic [IW-1:0]     cur_block;
  logic [LEN_W-1:0]  pos;
  logic [LEN_W-1:0]  cur_len;
  logic [IW:0]       cur_next;
  logic [COUNT_W-1:0] inst_count;
  logic [IW:0]       blocks_used;
  logic [ADDR_W-1:0] blk0_start;
  logic [LEN_W-1:0]  blk0_len;
  logic [IW:0]       blk0_next;
  logic              link_wait;
  logic [IW-1:0]     link_block;

  logic              accept;
  logic              at_end;
  logic              room;
  logic              do_open;
  logic              do_fall;
  logic              do_link;
  logic              do_step;
  logic [LEN_W-1:0]  len_fix;
  logic [IW-1:0]     new_idx;
  logic [IW-1:0]     link_idx;
  logic [IW:0]       wr_next;
  logic              wr_next_en;

  logic [ADDR_W-1:0] cur_addr_next;
  logic [IW-1:0]     cur_block_next;
  logic [LEN_W-1:0]  pos_next;
  logic [LEN_W-1:0]  cur_len_next;
  logic [IW:0]       cur_next_next;

  assign busy      = link_wait;
  assign cfg_ready = 1'b1;

  assign accept   = start && !busy;
  assign at_end   = started && (pos == cur_len);
  assign room     = (inst_count < unique_limit) && (blocks_used < DEPTH_CNT);
  assign do_open  = accept && (!started || (at_end && (cur_next == '0) && room));
  assign do_fall  = accept && at_end && (cur_next == '0) && !room;
  assign do_link  = accept && at_end && (cur_next != '0);
  assign do_step  = accept && started && !at_end;
  assign len_fix  = (req.fresh_len == '0) ? LEN_W'(1) : req.fresh_len;
  assign new_idx  = IW'(blocks_used);
  assign link_idx = IW'(cur_next - LINK_ONE);
  assign wr_next    = do_open ? (blocks_used + LINK_ONE) : LINK_ONE;
  assign wr_next_en = started && (do_open || do_fall);

  always_comb begin
    cur_addr_next  = cur_addr;
    cur_block_next = cur_block;
    pos_next       = pos;
    cur_len_next   = cur_len;
    cur_next_next  = cur_next;
    if (link_wait) begin
      cur_addr_next  = rd_start;
      cur_block_next = link_block;
      pos_next       = LEN_W'(1);
      cur_len_next   = rd_len;
      cur_next_next  = rd_next;
    end else if (do_open) begin
      cur_addr_next  = req.fresh_addr;
      cur_block_next = new_idx;
      pos_next       = LEN_W'(1);
      cur_len_next   = len_fix;
      cur_next_next  = '0;
    end else if (do_fall) begin
      cur_addr_next  = blk0_start;
      cur_block_next = '0;
      pos_next       = LEN_W'(1);
      cur_len_next   = blk0_len;
      cur_next_next  = (cur_block == '0) ? LINK_ONE : blk0_next;
    end else if (do_step) begin
      cur_addr_next  = cur_addr + ADDR_W'(address_step);
      pos_next       = pos + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_step <= ADDRESS_STEP_RST;
      unique_limit <= UNIQUE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ADDRESS_STEP: address_step <= cfg_data[STEP_W-1:0];
        CFG_UNIQUE_LIMIT: unique_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      cur_addr    <= '0;
      cur_block   <= '0;
      pos         <= '0;
      cur_len     <= '0;
      cur_next    <= '0;
      inst_count  <= '0;
      blocks_used <= '0;
      blk0_next   <= '0;
      link_wait   <= 1'b0;
      done        <= 1'b0;
    end else begin
      cur_addr  <= cur_addr_next;
      cur_block <= cur_block_next;
      pos       <= pos_next;
      cur_len   <= cur_len_next;
      cur_next  <= cur_next_next;
      link_wait <= do_link;
      done      <= link_wait || (accept && !do_link);
      if (accept) begin
        started <= 1'b1;
        if (inst_count != COUNT_MAX) begin
          inst_count <= inst_count + COUNT_W'(1);
        end
      end
      if (do_open) begin
        blocks_used <= blocks_used + LINK_ONE;
      end
      if (do_open && !started) begin
        blk0_next <= '0;
      end else if (wr_next_en && (cur_block == '0)) begin
        blk0_next <= wr_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (do_open && !started) begin
      blk0_start <= req.fresh_addr;
      blk0_len   <= len_fix;
    end
    if (do_link) begin
      link_block <= link_idx;
    end
    result.inst_addr   <= cur_addr_next;
    result.block_end   <= (pos_next == cur_len_next);
    result.block_index <= BLOCK_INDEX_W'(cur_block_next);
  end

  // table writes and registered read
  always_ff @(posedge clk) begin
    if (do_open) begin
      start_mem[new_idx] <= req.fresh_addr;
      len_mem[new_idx]   <= len_fix;
    end
    if (wr_next_en) begin
      next_mem[cur_block] <= wr_next;
    end
    rd_start <= start_mem[link_idx];
    rd_len   <= len_mem[link_idx];
    rd_next  <= next_mem[link_idx];
  end

endmodule

`default_nettype wire

// ===== sim/tb_basic_block_address_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_basic_block_address_generator_unit
// Self-checking bench for the basic block address generator. A behavioral
// tracker follows block creation, links and the step and limit registers, and predicts
// every fetch word; the monitor compares each done word field by field.
// ----------------------------------------------------------------------------
module tb_basic_block_address_generator_unit;
  import bbag_pkg::*;

  localparam int BLOCK_SLOTS = 1024;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = '1;
  localparam logic [BLOCK_INDEX_W:0] NO_LINK = '0;
  localparam logic [BLOCK_INDEX_W:0] LINK_HEAD = (BLOCK_INDEX_W+1)'(1);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  basic_block_address_generator_unit #(.TABLE_DEPTH(BLOCK_SLOTS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadows and block tracker
  logic [STEP_W-1:0]        step_shadow = ADDRESS_STEP_RST;
  logic [LIMIT_W-1:0]       limit_shadow = UNIQUE_LIMIT_RST;
  logic                     trk_started = 1'b0;
  logic [ADDR_W-1:0]        trk_addr = '0;
  logic [BLOCK_INDEX_W-1:0] trk_block = '0;
  logic [LEN_W-1:0]         trk_pos = '0;
  logic [LEN_W-1:0]         trk_len = '0;
  logic [COUNT_W-1:0]       trk_count = '0;
  logic [BLOCK_INDEX_W:0]   trk_used = '0;
  logic [ADDR_W-1:0]        bb_start [BLOCK_SLOTS];
  logic [LEN_W-1:0]         bb_len [BLOCK_SLOTS];
  logic [BLOCK_INDEX_W:0]   bb_link [BLOCK_SLOTS];

  req_t    pending_words[$];
  result_t expected_fetches[$];
  int words_issued = 0;
  int words_accepted = 0;
  int words_seen = 0;
  int branches_seen = 0;
  int reg_writes = 0;
  int errors = 0;
  int cycles = 0;
  int gap_left = 0;
  bit steady = 1'b0;

  function automatic void open_block(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
    logic [BLOCK_INDEX_W-1:0] slot;
    slot = trk_used[BLOCK_INDEX_W-1:0];
    if (trk_started) bb_link[trk_block] = trk_used + 1'b1;
    bb_start[slot] = addr;
    bb_len[slot] = (len == '0) ? LEN_W'(1) : len;
    bb_link[slot] = NO_LINK;
    trk_used = trk_used + 1'b1;
    trk_block = slot;
    trk_addr = addr;
    trk_len = bb_len[slot];
    trk_pos = '0;
  endfunction

  function automatic void goto_block(logic [BLOCK_INDEX_W-1:0] slot);
    trk_block = slot;
    trk_addr = bb_start[slot];
    trk_len = bb_len[slot];
    trk_pos = '0;
  endfunction

  function automatic result_t next_fetch_addr(req_t w);
    logic [BLOCK_INDEX_W:0] link;
    result_t res;
    if (!trk_started) begin
      open_block(w.fresh_addr, w.fresh_len);
      trk_started = 1'b1;
    end else if (trk_pos == trk_len) begin
      link = bb_link[trk_block];
      if (link != NO_LINK) begin
        goto_block(BLOCK_INDEX_W'(link - 1'b1));
      end else if (trk_count < limit_shadow && trk_used < BLOCK_SLOTS) begin
        open_block(w.fresh_addr, w.fresh_len);
      end else begin
        bb_link[trk_block] = LINK_HEAD;
        goto_block('0);
      end
    end else begin
      trk_addr = trk_addr + ADDR_W'(step_shadow);
    end
    trk_pos = trk_pos + 1'b1;
    if (trk_count != COUNT_MAX) trk_count = trk_count + 1'b1;
    res.inst_addr = trk_addr;
    res.block_end = (trk_pos == trk_len);
    res.block_index = trk_block;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [ADDR_W-1:0] got,
                               input logic [ADDR_W-1:0] want);
    errors++;
    if (errors <= 50) $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  function automatic int pick_gap();
    int roll;
    if ($urandom_range(0, 39) == 0) steady = !steady;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    if ($urandom_range(0, 9) == 0) return {52'hF_FFFF_FFFF_FFFF, 12'($urandom)};
    return {$urandom, $urandom};
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 85) return LEN_W'($urandom_range(1, 8));
    if (roll < 97) return LEN_W'($urandom_range(9, 64));
    if (roll < 99) return LEN_W'($urandom_range(65, 254));
    return '1;
  endfunction

  task automatic push_word(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
    req_t w;
    w.fresh_addr = addr;
    w.fresh_len = len;
    pending_words.push_back(w);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || words_accepted != words_issued ||
           expected_fetches.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain();
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (cfg_ready !== 1'b1);
    if (idx == CFG_ADDRESS_STEP) step_shadow = val[STEP_W-1:0];
    else if (idx == CFG_UNIQUE_LIMIT) limit_shadow = val[LIMIT_W-1:0];
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int n);
    repeat (n) push_word(rand_addr(), rand_len());
    drain();
  endtask

  // driver: one word per handshake, random gaps between words
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || words_accepted == words_issued) begin
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_words.size() != 0) begin
        req <= pending_words.pop_front();
        start <= 1'b1;
        words_issued++;
        gap_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check done words first, then record any word taken at this edge
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (done === 1'b1) begin
        words_seen++;
        if (result.block_end === 1'b1) branches_seen++;
        if (expected_fetches.size() == 0) begin
          flag_mismatch("unexpected word", result.inst_addr, '0);
        end else begin
          want = expected_fetches.pop_front();
          if (result.inst_addr !== want.inst_addr)
            flag_mismatch("inst_addr", result.inst_addr, want.inst_addr);
          if (result.block_end !== want.block_end)
            flag_mismatch("block_end", ADDR_W'(result.block_end),
                          ADDR_W'(want.block_end));
          if (result.block_index !== want.block_index)
            flag_mismatch("block_index", ADDR_W'(result.block_index),
                          ADDR_W'(want.block_index));
        end
      end
      if (start && !busy) begin
        expected_fetches.push_back(next_fetch_addr(req));
        words_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset register values; second word wraps past the top of the address space
    push_word('1, 8'd2);
    push_word('0, 8'd0);
    push_word('0, 8'd0);
    drain();

    // zero step: addresses hold inside a block
    write_reg(CFG_ADDRESS_STEP, 16'h0000);
    write_reg(CFG_UNIQUE_LIMIT, 16'hFFFF);
    push_word(64'h5555_5555_5555_5555, 8'd3);
    push_word('1, '1);
    push_word(64'hAAAA_AAAA_AAAA_AAAA, 8'hAA);
    push_word(64'h0000_0000_0000_0001, 8'd1);
    push_word(64'hAAAA_AAAA_AAAA_AAAA, 8'd4);
    push_word('1, 8'h55);
    push_word('0, 8'h80);
    push_word(64'h8000_0000_0000_0000, 8'h7F);
    drain();

    // step field masked to its width; write to an unmapped index is dropped
    write_reg(CFG_ADDRESS_STEP, 16'hFFFF);
    write_reg(CFG_NO_REG, 16'h1234);
    push_word(64'hFFFF_FFFF_FFFF_F800, 8'd5);
    push_word('0, '1);
    push_word('1, '0);
    push_word(64'h0F0F_0F0F_0F0F_0F0F, 8'h0F);
    push_word(64'hF0F0_F0F0_F0F0_F0F0, 8'hF0);
    push_word(64'h0123_4567_89AB_CDEF, 8'd1);
    drain();

    write_reg(CFG_ADDRESS_STEP, 16'd1);
    run_random(125);
    write_reg(CFG_ADDRESS_STEP, CFG_DATA_W'($urandom_range(1, 4095)));
    run_random(125);

    // short blocks until the table is full
    write_reg(CFG_ADDRESS_STEP, 16'd8);
    while (trk_used < BLOCK_SLOTS) begin
      repeat (32) push_word(rand_addr(), LEN_W'($urandom_range(0, 1)));
      drain();
    end

    write_reg(CFG_UNIQUE_LIMIT, 16'h0000);
    write_reg(CFG_ADDRESS_STEP, 16'd4095);
    run_random(125);
    write_reg(CFG_UNIQUE_LIMIT, CFG_DATA_W'($urandom));
    write_reg(CFG_ADDRESS_STEP, CFG_DATA_W'($urandom_range(1, 4095)));
    run_random(125);

    drain();
    repeat (10) @(posedge clk);
    $display("checked %0d words (%0d branches) over %0d blocks, %0d register writes",
             words_seen, branches_seen, trk_used, reg_writes);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
